>>> hdl/kwrl_pkg.sv
// kwrl_pkg: shared widths, constants and register codes for the keyed window
// rate limiter. Depends on nothing; imported by the limiter core.
`default_nettype none

package kwrl_pkg;

    // Field widths
    localparam int KEY_W  = 64;
    localparam int TS_W   = 64;
    localparam int SEC_W  = 55;   // (2^64 - 1) / 1000 needs 55 bits
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 16;

    // Stream payload widths (padded to whole bytes)
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 40;

    // Millisecond to second divider: remainder stays below 1000
    localparam int REM_W             = 10;
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = TS_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);
    localparam logic [REM_W:0] MS_PER_SECOND = 11'd1000;

    localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] WINDOW_SECONDS_RST     = 16'd5;
    localparam logic [CFG_W-1:0] ALLOWED_PER_WINDOW_RST = 16'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SECONDS     = 2'd0,
        CFG_ALLOWED_PER_WINDOW = 2'd1
    } t_cfg_index;

endpackage : kwrl_pkg

`default_nettype wire

>>> hdl/keyed_window_rate_limiter_core.sv
// Keyed fixed-window rate limiter core with a least-recently-used entry table.
// Depends on kwrl_pkg (widths, constants) and kwrl_ram (entry storage).
//
// Each event carries a pre-hashed 64-bit flow key and a millisecond timestamp.
// The block looks the key up in a fully associative table of TABLE_ENTRIES
// entries, opens a new window (count 1, allowed) on a miss, an expired window
// or a timestamp that went backwards, and otherwise counts the event and
// allows it while the count stays at or below allowed_per_window. Exactly one
// result follows each event. One event is in work at a time: the core makes a
// lookup pass over the entry RAM (the 4-bit-per-cycle millisecond divider runs
// alongside), a decision step, an update pass that rewrites every row's recency
// rank, and a posting step for the result. The core is ready again in the cycle
// the result appears, so it takes no new event before it is through with the
// last; a result still waiting from the previous event holds the core in its
// posting state. The single read port of the entry RAM makes each pass walk
// the table one entry at a time. Entries fill from the highest index down, so a
// fill count stands in for valid bits and the RAM needs no clearing after reset.
// Configuration writes land at once and are to be made only while the core is
// idle.
`default_nettype none

module keyed_window_rate_limiter_core #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Event stream in
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [63:0] flow_key, [127:64] timestamp_ms
    input  wire logic [kwrl_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // Result stream out
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [0] allowed, [32:1] window_count, [33] window_restarted, [39:34] zero
    output logic      [kwrl_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [kwrl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kwrl_pkg::CFG_W-1:0]        i_cfg_data
);

    import kwrl_pkg::*;

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int FW     = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W  = KEY_W + SEC_W + CNT_W + AW;
    localparam int CNT_LO = AW;
    localparam int SEC_LO = AW + CNT_W;
    localparam int KEY_LO = AW + CNT_W + SEC_W;

    localparam logic [AW:0]   PTR_END    = (AW + 1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX   = AW'(TABLE_ENTRIES - 1);
    localparam logic [FW:0]   FILL_END_X = (FW + 1)'(TABLE_ENTRIES);
    localparam logic [FW-1:0] FILL_FULL  = FW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state r_state;

    // Event under work
    logic [KEY_W-1:0]     r_key;
    logic [TS_W-1:0]      r_div_num;   // dividend shifts out, quotient shifts in
    logic [REM_W-1:0]     r_div_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // RAM pass sequencing
    logic [AW:0]          r_ptr;
    logic                 r_chk_vld;
    logic [AW-1:0]        r_chk_idx;

    // Lookup results
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic [AW-1:0]        r_hit_rank;
    logic [SEC_W-1:0]     r_hit_start;
    logic [CNT_W-1:0]     r_hit_count;
    logic [AW-1:0]        r_vic_idx;

    // Decision
    logic [AW-1:0]        r_slot;
    logic [AW-1:0]        r_old_rank;
    logic                 r_restart;
    logic [CNT_W-1:0]     r_new_count;
    logic                 r_fill_inc;
    logic [FW-1:0]        r_fill;

    // Output and configuration
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [CFG_W-1:0]       r_win;
    logic [CFG_W-1:0]       r_thr;

    // Entry RAM: {key, window start, count, recency rank}
    logic             ram_we;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] n_wrow;

    kwrl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_chk_idx),
        .i_wdata (n_wrow),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Row fields of the entry just read
    logic [KEY_W-1:0] w_rd_key;
    logic [SEC_W-1:0] w_rd_start;
    logic [CNT_W-1:0] w_rd_count;
    logic [AW-1:0]    w_rd_rank;
    logic             w_rd_valid;

    assign w_rd_key   = ram_rdata[KEY_LO +: KEY_W];
    assign w_rd_start = ram_rdata[SEC_LO +: SEC_W];
    assign w_rd_count = ram_rdata[CNT_LO +: CNT_W];
    assign w_rd_rank  = ram_rdata[AW-1:0];
    // Filled entries occupy the top r_fill indexes
    assign w_rd_valid = ({{(FW + 1 - AW){1'b0}}, r_chk_idx} + {1'b0, r_fill}) >= FILL_END_X;

    // Divider step: four restoring steps by 1000 per cycle
    logic [TS_W-1:0]  n_div_num;
    logic [REM_W-1:0] n_div_rem;

    always_comb begin
        logic [REM_W:0] v_rem;
        n_div_num = r_div_num;
        n_div_rem = r_div_rem;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
            v_rem     = {n_div_rem, n_div_num[TS_W-1]};
            n_div_num = {n_div_num[TS_W-2:0], 1'b0};
            if (v_rem >= MS_PER_SECOND) begin
                v_rem        = v_rem - MS_PER_SECOND;
                n_div_num[0] = 1'b1;
            end
            n_div_rem = v_rem[REM_W-1:0];
        end
    end

    // Window decision on the looked-up entry
    logic [SEC_W-1:0] w_now;
    logic [SEC_W:0]   w_end;
    logic             w_restart;
    logic [CNT_W-1:0] w_inc_count;

    assign w_now       = r_div_num[SEC_W-1:0];
    assign w_end       = {1'b0, r_hit_start} + (SEC_W + 1)'(r_win);
    assign w_restart   = !r_hit || (w_end < {1'b0, w_now}) || (r_hit_start > w_now);
    assign w_inc_count = (r_hit_count == COUNT_MAX) ? r_hit_count
                                                    : r_hit_count + CNT_W'(1);

    // Update pass: rewrite the chosen slot, age the more recent entries
    always_comb begin
        if (r_chk_idx == r_slot) begin
            n_wrow = {r_key, (r_restart ? w_now : w_rd_start), r_new_count, {AW{1'b0}}};
        end else if (w_rd_valid && (w_rd_rank < r_old_rank)) begin
            n_wrow = {w_rd_key, w_rd_start, w_rd_count, w_rd_rank + AW'(1)};
        end else begin
            n_wrow = ram_rdata;
        end
    end

    assign ram_we = (r_state == S_UPDATE) && r_chk_vld;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Sequencer, datapath registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_win       <= WINDOW_SECONDS_RST;
            r_thr       <= ALLOWED_PER_WINDOW_RST;
            r_hit       <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_div_cnt   <= '0;
            r_ptr       <= '0;
            r_fill_inc  <= 1'b0;
        end else begin
            // Configuration writes; unknown indexes are dropped
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_WINDOW_SECONDS:     r_win <= i_cfg_data;
                    CFG_ALLOWED_PER_WINDOW: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end

            // Result transaction taken
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // RAM read sequencing shared by both passes
            if ((r_state == S_SCAN) || (r_state == S_UPDATE)) begin
                if (r_ptr != PTR_END) begin
                    r_ptr     <= r_ptr + (AW + 1)'(1);
                    r_chk_vld <= 1'b1;
                    r_chk_idx <= r_ptr[AW-1:0];
                end else begin
                    r_chk_vld <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_key     <= i_s_axis_tdata[KEY_W-1:0];
                        r_div_num <= i_s_axis_tdata[KEY_W +: TS_W];
                        r_div_rem <= '0;
                        r_div_cnt <= DIV_CNT_W'(DIV_STEPS);
                        r_ptr     <= '0;
                        r_chk_vld <= 1'b0;
                        r_hit     <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (r_div_cnt != '0) begin
                        r_div_num <= n_div_num;
                        r_div_rem <= n_div_rem;
                        r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                    end
                    // Tag match and least recent entry
                    if (r_chk_vld && w_rd_valid) begin
                        if (!r_hit && (w_rd_key == r_key)) begin
                            r_hit       <= 1'b1;
                            r_hit_idx   <= r_chk_idx;
                            r_hit_rank  <= w_rd_rank;
                            r_hit_start <= w_rd_start;
                            r_hit_count <= w_rd_count;
                        end
                        if (w_rd_rank == LAST_IDX) begin
                            r_vic_idx <= r_chk_idx;
                        end
                    end
                    if ((r_ptr == PTR_END) && !r_chk_vld && (r_div_cnt == '0)) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    r_restart   <= w_restart;
                    r_new_count <= w_restart ? CNT_W'(1) : w_inc_count;
                    priority if (r_hit) begin
                        r_slot     <= r_hit_idx;
                        r_old_rank <= r_hit_rank;
                        r_fill_inc <= 1'b0;
                    end else if (r_fill == FILL_FULL) begin
                        r_slot     <= r_vic_idx;
                        r_old_rank <= LAST_IDX;
                        r_fill_inc <= 1'b0;
                    end else begin
                        // Free entries are taken from the top index down
                        r_slot     <= LAST_IDX - r_fill[AW-1:0];
                        r_old_rank <= r_fill[AW-1:0];
                        r_fill_inc <= 1'b1;
                    end
                    r_ptr     <= '0;
                    r_chk_vld <= 1'b0;
                    r_state   <= S_UPDATE;
                end

                S_UPDATE: begin
                    if ((r_ptr == PTR_END) && !r_chk_vld) begin
                        if (r_fill_inc) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        r_state <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    if (!r_out_valid) begin
                        r_out_data  <= {{(OUT_TDATA_W - CNT_W - 2){1'b0}}, r_restart,
                                        r_new_count,
                                        r_restart || (r_new_count <= CNT_W'(r_thr))};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A new transaction is never taken in the cycle after one was taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("event accepted while previous one in work");

    // A restarted window always reports a count of one
    a_restart_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[CNT_W+1]) |-> (o_m_axis_tdata[CNT_W:1] == CNT_W'(1)))
        else $error("restarted window with count other than one");

    // A dropped event must be over the threshold
    a_drop_over_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[CNT_W:1] > CNT_W'(r_thr)))
        else $error("event dropped within its limit");

    // Fill count only grows and never passes the table size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_fill >= $past(r_fill)) && (r_fill <= FILL_FULL)))
        else $error("entry fill count out of order");

endmodule : keyed_window_rate_limiter_core

`default_nettype wire

>>> hdl/kwrl_ram.sv
// kwrl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module kwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule : kwrl_ram

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench: self-checking bench for keyed_window_rate_limiter_core.
// Depends on kwrl_pkg and the limiter core; holds its own model of the LRU
// window table; checks every result against it or against a directed row's verdict.
`default_nettype none

module testbench;
    import kwrl_pkg::*;

    localparam int N_SLOTS       = 32;
    localparam int CORE_LATENCY  = 2 * N_SLOTS + 6;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int N_PHASES      = 8;
    localparam int PHASE_EVENTS  = 200;
    localparam int POOL_KEYS     = 40;
    localparam int HOT_KEYS      = 8;
    localparam int N_ROWS        = 18;

    // Indexes past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

    localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_B = 64'hAAAA_5555_AAAA_5555;
    localparam logic [KEY_W-1:0] KEY_C = 64'd5;
    localparam logic [KEY_W-1:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic             allowed;
        logic [CNT_W-1:0] count;
        logic             restarted;
    } rl_verdict_t;

    typedef struct {
        bit               reconfig;
        logic [CFG_W-1:0] win;
        logic [CFG_W-1:0] thr;
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  ts;
        bit               typed;
        rl_verdict_t      verdict;
    } stim_row_t;

    // DUT connections
    logic                    i_clk;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index     = '0;
    logic [CFG_W-1:0]        i_cfg_data      = '0;

    keyed_window_rate_limiter_core #(
        .TABLE_ENTRIES (N_SLOTS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Model copy of the window table and the registers
    logic [KEY_W-1:0] slot_key     [N_SLOTS];
    logic [SEC_W-1:0] slot_start_s [N_SLOTS];
    logic [CNT_W-1:0] slot_count   [N_SLOTS];
    logic             slot_valid   [N_SLOTS];
    logic [4:0]       slot_rank    [N_SLOTS];
    logic [CFG_W-1:0] win_len_s;
    logic [CFG_W-1:0] max_per_win;

    rl_verdict_t pending_verdicts[$];
    stim_row_t   directed_rows [N_ROWS];
    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    int errors        = 0;
    int events_sent   = 0;
    int seen_allowed  = 0;
    int seen_dropped  = 0;
    int seen_restarts = 0;
    int settings_used = 1;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int quiet_cycles  = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Judge one event against the model table and update it
    task automatic judge_event(input logic [KEY_W-1:0] key, input logic [TS_W-1:0] ts,
                               output rl_verdict_t v);
        logic [63:0] now_s;
        logic [63:0] win_end;
        logic [4:0]  oldest;
        logic [4:0]  old_rank;
        int          slot;
        int          i;
        bit          hit;
        bit          restart;
        now_s = ts / 64'd1000;
        hit = 1'b0;
        slot = 0;
        for (i = 0; i < N_SLOTS; i++) begin
            if (!hit && slot_valid[i] && slot_key[i] == key) begin
                slot = i;
                hit = 1'b1;
            end
        end
        // Miss: take the least recently used slot
        if (!hit) begin
            oldest = '0;
            for (i = 0; i < N_SLOTS; i++) begin
                if (slot_rank[i] >= oldest) begin
                    oldest = slot_rank[i];
                    slot = i;
                end
            end
        end
        win_end = {9'd0, slot_start_s[slot]} + {48'd0, win_len_s};
        restart = !hit || (win_end < now_s) || ({9'd0, slot_start_s[slot]} > now_s);
        if (restart) begin
            slot_key[slot]     = key;
            slot_valid[slot]   = 1'b1;
            slot_start_s[slot] = now_s[SEC_W-1:0];
            slot_count[slot]   = 32'd1;
            v.allowed          = 1'b1;
        end else begin
            if (slot_count[slot] != COUNT_MAX)
                slot_count[slot] = slot_count[slot] + 32'd1;
            v.allowed = (slot_count[slot] <= {16'd0, max_per_win});
        end
        // Refresh recency
        old_rank = slot_rank[slot];
        for (i = 0; i < N_SLOTS; i++) begin
            if (slot_rank[i] < old_rank)
                slot_rank[i] = slot_rank[i] + 5'd1;
        end
        slot_rank[slot] = '0;
        v.count     = slot_count[slot];
        v.restarted = restart;
    endtask

    function automatic stim_row_t make_row(bit reconfig, logic [CFG_W-1:0] win,
                                           logic [CFG_W-1:0] thr, logic [KEY_W-1:0] key,
                                           logic [TS_W-1:0] ts, bit typed, logic a,
                                           logic [CNT_W-1:0] c, logic r);
        stim_row_t row;
        row.reconfig          = reconfig;
        row.win               = win;
        row.thr               = thr;
        row.key               = key;
        row.ts                = ts;
        row.typed             = typed;
        row.verdict.allowed   = a;
        row.verdict.count     = c;
        row.verdict.restarted = r;
        return row;
    endfunction

    // Send one event transaction; the expectation is queued on acceptance
    task automatic send_event(input logic [KEY_W-1:0] key, input logic [TS_W-1:0] ts,
                              input bit typed, input rl_verdict_t typed_v);
        rl_verdict_t v;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ts, key};
        do @(posedge i_clk); while (!o_s_axis_tready);
        judge_event(key, ts, v);
        pending_verdicts.push_back(typed ? typed_v : v);
        events_sent++;
    endtask

    // Let every outstanding result come back before touching registers
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers plus the two unused indexes (ignored)
    task automatic set_limits(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] thr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WINDOW_SECONDS;
        i_cfg_data  <= win;
        @(posedge i_clk);
        i_cfg_index <= CFG_ALLOWED_PER_WINDOW;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_SPARE_LO;
        i_cfg_data  <= 16'($urandom_range(0, 65535));
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_SPARE_HI;
        i_cfg_data  <= 16'($urandom_range(0, 65535));
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        win_len_s   = win;
        max_per_win = thr;
        settings_used++;
    endtask

    // Result checker and receiver back-pressure
    always @(posedge i_clk) begin
        rl_verdict_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (o_m_axis_tdata[0]) seen_allowed++;
            else seen_dropped++;
            if (o_m_axis_tdata[33]) seen_restarts++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result transaction, got %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_m_axis_tdata[0] !== want.allowed) begin
                    $display("%0t: allowed mismatch, expected %0d, got %0d",
                             $time, want.allowed, o_m_axis_tdata[0]);
                    errors++;
                end
                if (o_m_axis_tdata[32:1] !== want.count) begin
                    $display("%0t: window_count mismatch, expected %0d, got %0d",
                             $time, want.count, o_m_axis_tdata[32:1]);
                    errors++;
                end
                if (o_m_axis_tdata[33] !== want.restarted) begin
                    $display("%0t: window_restarted mismatch, expected %0d, got %0d",
                             $time, want.restarted, o_m_axis_tdata[33]);
                    errors++;
                end
                if (o_m_axis_tdata[39:34] !== 6'd0) begin
                    $display("%0t: pad bits mismatch, expected 0, got %h",
                             $time, o_m_axis_tdata[39:34]);
                    errors++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog: too long without any transaction
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        logic [CFG_W-1:0] phase_win [N_PHASES];
        logic [CFG_W-1:0] phase_thr [N_PHASES];
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  cur_ts;
        rl_verdict_t      no_verdict;
        int               r;
        int               p;
        int               n;

        no_verdict = '0;
        for (n = 0; n < N_SLOTS; n++) begin
            slot_key[n]     = '0;
            slot_start_s[n] = '0;
            slot_count[n]   = '0;
            slot_valid[n]   = 1'b0;
            slot_rank[n]    = n[4:0];
        end
        win_len_s   = WINDOW_SECONDS_RST;
        max_per_win = ALLOWED_PER_WINDOW_RST;

        // Directed rows: reset settings, then zero, full-scale and tiny limits
        directed_rows[0]  = make_row(0, 0, 0, 64'd0, 64'd0, 1, 1, 1, 1);  // key 0 misses
        directed_rows[1]  = make_row(0, 0, 0, 64'd0, 64'd0, 1, 1, 2, 0);
        directed_rows[2]  = make_row(0, 0, 0, ONES, ONES, 1, 1, 1, 1);
        directed_rows[3]  = make_row(0, 0, 0, ONES, 64'd0, 1, 1, 1, 1);   // clock went back
        directed_rows[4]  = make_row(0, 0, 0, 64'd0, 64'd5999, 1, 1, 3, 0);
        directed_rows[5]  = make_row(0, 0, 0, 64'd0, 64'd6000, 1, 1, 1, 1); // expired
        directed_rows[6]  = make_row(1, 0, 0, KEY_A, 64'd1000, 1, 1, 1, 1);
        directed_rows[7]  = make_row(0, 0, 0, KEY_A, 64'd1999, 1, 0, 2, 0); // zero threshold
        directed_rows[8]  = make_row(0, 0, 0, KEY_A, 64'd2000, 1, 1, 1, 1); // zero window ends
        directed_rows[9]  = make_row(0, 0, 0, 64'd0, 64'd2000, 0, 0, 0, 0);
        directed_rows[10] = make_row(1, 16'hFFFF, 16'hFFFF, KEY_B, 64'd0, 0, 0, 0, 0);
        directed_rows[11] = make_row(0, 0, 0, KEY_B, 64'd65535000, 0, 0, 0, 0);
        directed_rows[12] = make_row(0, 0, 0, KEY_B, 64'd65536000, 0, 0, 0, 0);
        directed_rows[13] = make_row(0, 0, 0, ONES, ONES, 0, 0, 0, 0);
        directed_rows[14] = make_row(1, 16'd1, 16'd2, KEY_C, 64'd0, 0, 0, 0, 0);
        directed_rows[15] = make_row(0, 0, 0, KEY_C, 64'd1, 0, 0, 0, 0);
        directed_rows[16] = make_row(0, 0, 0, KEY_C, 64'd1999, 0, 0, 0, 0);
        directed_rows[17] = make_row(0, 0, 0, KEY_C, 64'd2000, 0, 0, 0, 0);

        // Random phases: fixed corners plus a few drawn settings
        phase_win[0] = 16'd5;     phase_thr[0] = 16'd10;
        phase_win[1] = 16'd0;     phase_thr[1] = 16'd0;
        phase_win[2] = 16'hFFFF;  phase_thr[2] = 16'hFFFF;
        phase_win[3] = 16'd1;     phase_thr[3] = 16'd3;
        phase_win[4] = 16'($urandom_range(0, 4));
        phase_thr[4] = 16'($urandom_range(0, 8));
        phase_win[5] = 16'($urandom_range(0, 65535));
        phase_thr[5] = 16'($urandom_range(0, 65535));
        phase_win[6] = 16'd2;     phase_thr[6] = 16'd1;
        phase_win[7] = 16'($urandom_range(0, 4));
        phase_thr[7] = 16'($urandom_range(0, 8));
        for (n = 0; n < POOL_KEYS; n++)
            key_pool[n] = {$urandom(), $urandom()};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling
        for (n = 0; n < N_ROWS; n++) begin
            if (directed_rows[n].reconfig) begin
                drain_results();
                set_limits(directed_rows[n].win, directed_rows[n].thr);
            end
            send_event(directed_rows[n].key, directed_rows[n].ts,
                       directed_rows[n].typed, directed_rows[n].verdict);
        end

        // Random part: mostly a small hot key set on a slowly moving clock,
        // a wider pool to force LRU eviction, some backward jumps and noise
        for (p = 0; p < N_PHASES; p++) begin
            drain_results();
            set_limits(phase_win[p], phase_thr[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
                default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
            endcase
            cur_ts = {$urandom(), $urandom()};
            for (n = 0; n < PHASE_EVENTS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    key = {$urandom(), $urandom()};
                    ts  = {$urandom(), $urandom()};
                end else begin
                    if ($urandom_range(0, 99) < 70)
                        key = key_pool[$urandom_range(0, HOT_KEYS - 1)];
                    else
                        key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                    if (r < 9)
                        cur_ts = cur_ts - 64'($urandom_range(1, 20000));
                    else
                        cur_ts = cur_ts + 64'($urandom_range(0, 700));
                    ts = cur_ts;
                end
                send_event(key, ts, 1'b0, no_verdict);
            end
        end

        tx_idle_pct = 0;
        drain_results();
        repeat (2 * CORE_LATENCY) @(posedge i_clk);

        $display("ran %0d events under %0d register settings with all idle/stall mixes",
                 events_sent, settings_used);
        $display("results: %0d passed, %0d dropped, %0d opened a window",
                 seen_allowed, seen_dropped, seen_restarts);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/kwrl_pkg.sv
hdl/kwrl_ram.sv
hdl/keyed_window_rate_limiter_core.sv
tb/sv/testbench.sv
